FILE: hw/rtl/srrw_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// srrw_pkg
// Shared widths, codes and controller/datapath interface types for the
// selective-repeat receive window.
// ---------------------------------------------------------------------------
package srrw_pkg;

    localparam int WINDOW_MAX  = 16;
    localparam int PAYLOAD_MAX = 1024;

    localparam int IDX_W    = $clog2(WINDOW_MAX);
    localparam int CNT_W    = $clog2(WINDOW_MAX + 1);
    localparam int SEQ_W    = 31;
    localparam int WS_W     = 32;
    localparam int HANDLE_W = 16;
    localparam int LEN_W    = 11;
    localparam int KIND_W   = 2;
    localparam int WSZ_W    = 5;
    localparam int SLOT_W   = HANDLE_W + LEN_W;

    localparam int IN_TDATA_W  = 64;
    localparam int IN_TUSER_W  = KIND_W + 1;
    localparam int OUT_TDATA_W = 64;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (SEQ_W + HANDLE_W + LEN_W);

    localparam logic [WSZ_W-1:0] WSZ_RESET = WSZ_W'(16);

    localparam logic [KIND_W-1:0] KIND_SYN  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIN  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DATA = 2'd2;

    localparam logic RES_ACK = 1'b0;
    localparam logic RES_DLV = 1'b1;

    typedef struct packed {
        logic load_in;
        logic set_open;
        logic fin;
        logic store;
        logic scan_step;
        logic advance;
        logic ack_load;
        logic ack_sel_ws;
        logic ack_last;
        logic dlv_load;
        logic rd_req;
    } srrw_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              crc_ok;
        logic              beyond;
        logic              below;
        logic              at_start;
        logic              out_free;
        logic              scan_go;
        logic              cnt_last;
    } srrw_status_t;

endpackage
`default_nettype wire

FILE: hw/rtl/selective_repeat_receiver_window.sv
// Flow: a packet beat is captured, classified in EVAL and acknowledged from ACK into
// the result register; a packet at the window start first scans the window one slot a
// cycle, then sends the ack and one delivery beat a cycle while the output is not stalled.
// Packets are taken one at a time: the next is taken only once the controller is back
// in idle after the previous packet.
// Reset: synchronous, active low; window start 0, window empty, size 16.
`default_nettype none
// ---------------------------------------------------------------------------
// selective_repeat_receiver_window
// Selective-repeat receive reorder window: acknowledges control and accepted data packets and
// releases stored payload descriptors in sequence order.
// ---------------------------------------------------------------------------
module selective_repeat_receiver_window
    import srrw_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_wr_en,
    input  wire logic [WSZ_W-1:0]        cfg_wr_data,   // slots ahead of window start
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [IN_TDATA_W-1:0]   s_tdata,       // seq_num, payload_handle, payload_len
    input  wire logic [IN_TUSER_W-1:0]   s_tuser,       // packet_kind, crc_ok
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [OUT_TDATA_W-1:0]       m_tdata,       // ack_seq, deliver_handle, deliver_len
    output logic                         m_tlast,       // last
    output logic [0:0]                   m_tuser        // result_kind
);

    srrw_cmd_t    cmd;
    srrw_status_t sts;

    srrw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    srrw_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cmd         (cmd),
        .sts         (sts),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule
`default_nettype wire

FILE: hw/rtl/srrw_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// srrw_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module srrw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/srrw_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// srrw_ctrl
// Sequencer: classifies the packet, runs the window scan, then issues the
// acknowledgement and the in-order delivery beats.
// ---------------------------------------------------------------------------
module srrw_ctrl
    import srrw_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire srrw_status_t sts,
    output srrw_cmd_t         cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EVAL  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_ACK   = 3'd3;
    localparam logic [2:0] ST_DELIV = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       sel_ws_reg, sel_ws_next;
    logic       last_reg, last_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            sel_ws_reg <= 1'b0;
            last_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            sel_ws_reg <= sel_ws_next;
            last_reg   <= last_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next  = state_reg;
        sel_ws_next = sel_ws_reg;
        last_next   = last_reg;
        cmd         = '0;
        cmd.ack_sel_ws = sel_ws_reg;
        cmd.ack_last   = last_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL: begin
                state_next = ST_IDLE;
                case (sts.kind)
                    KIND_SYN: begin
                        cmd.set_open = 1'b1;
                        sel_ws_next  = 1'b0;
                        last_next    = 1'b1;
                        state_next   = ST_ACK;
                    end
                    KIND_FIN: begin
                        cmd.fin     = 1'b1;
                        sel_ws_next = 1'b0;
                        last_next   = 1'b1;
                        state_next  = ST_ACK;
                    end
                    KIND_DATA: begin
                        if (!sts.beyond && sts.crc_ok) begin
                            sel_ws_next = 1'b1;
                            last_next   = 1'b1;
                            if (sts.below) begin
                                state_next = ST_ACK;
                            end else begin
                                cmd.store  = 1'b1;
                                state_next = sts.at_start ? ST_SCAN : ST_ACK;
                            end
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_SCAN: begin
                if (sts.scan_go) begin
                    cmd.scan_step = 1'b1;
                end else begin
                    cmd.advance = 1'b1;
                    sel_ws_next = 1'b1;
                    last_next   = 1'b0;
                    state_next  = ST_ACK;
                end
            end
            ST_ACK: begin
                cmd.rd_req = 1'b1;
                if (sts.out_free) begin
                    cmd.ack_load = 1'b1;
                    state_next   = last_reg ? ST_IDLE : ST_DELIV;
                end
            end
            ST_DELIV: begin
                if (sts.out_free) begin
                    cmd.dlv_load = 1'b1;
                    cmd.rd_req   = 1'b1;
                    if (sts.cnt_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: hw/rtl/srrw_datapath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// srrw_datapath
// Window start, circular slot store with full flags, scan counter and the
// result register.
// ---------------------------------------------------------------------------
module srrw_datapath
    import srrw_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [WSZ_W-1:0]       cfg_wr_data,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire logic [IN_TUSER_W-1:0]  s_tuser,
    input  wire srrw_cmd_t              cmd,
    output srrw_status_t                sts,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    output logic                        m_tlast,
    output logic [0:0]                  m_tuser
);

    logic [WSZ_W-1:0]    wsz_reg;
    logic [WS_W-1:0]     ws_reg;
    logic                open_reg;
    logic [WINDOW_MAX-1:0] full_reg;
    logic [IDX_W-1:0]    base_reg;
    logic [IDX_W-1:0]    scan_ptr_reg;
    logic [CNT_W-1:0]    cnt_reg;

    logic [KIND_W-1:0]   kind_reg;
    logic [SEQ_W-1:0]    seq_reg;
    logic                crc_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [LEN_W-1:0]    len_reg;

    logic                out_valid_reg;
    logic                out_kind_reg;
    logic                out_last_reg;
    logic [SEQ_W-1:0]    out_ack_reg;
    logic [HANDLE_W-1:0] out_handle_reg;
    logic [LEN_W-1:0]    out_len_reg;

    logic [CNT_W-1:0]    wsz_eff;
    logic [WS_W-1:0]     seq_ext;
    logic [WS_W:0]       win_end;
    logic [WS_W-1:0]     offset;
    logic [IDX_W:0]      phys_sum;
    logic [IDX_W-1:0]    phys;
    logic [IDX_W-1:0]    base_inc;
    logic [IDX_W-1:0]    scan_inc;
    logic [LEN_W-1:0]    len_sat;
    logic [SLOT_W-1:0]   rd_data;
    logic                out_free;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] v);
        logic [IDX_W:0] s;
        s = {1'b0, v} + (IDX_W+1)'(1);
        if (s >= (IDX_W+1)'(WINDOW_MAX)) begin
            s = s - (IDX_W+1)'(WINDOW_MAX);
        end
        return s[IDX_W-1:0];
    endfunction

    // effective window size, clamped
    always_comb begin
        if (wsz_reg == '0) begin
            wsz_eff = CNT_W'(1);
        end else if ({{(CNT_W > WSZ_W ? CNT_W - WSZ_W : 0){1'b0}}, wsz_reg}
                     > (CNT_W > WSZ_W ? CNT_W : WSZ_W)'(WINDOW_MAX)) begin
            wsz_eff = CNT_W'(WINDOW_MAX);
        end else begin
            wsz_eff = CNT_W'(wsz_reg);
        end
    end

    assign seq_ext  = WS_W'(seq_reg);
    assign win_end  = {1'b0, ws_reg} + (WS_W+1)'(wsz_eff);
    assign offset   = seq_ext - ws_reg;
    assign phys_sum = {1'b0, base_reg} + {1'b0, offset[IDX_W-1:0]};
    assign phys     = (phys_sum >= (IDX_W+1)'(WINDOW_MAX))
                      ? IDX_W'(phys_sum - (IDX_W+1)'(WINDOW_MAX))
                      : phys_sum[IDX_W-1:0];
    assign base_inc = idx_inc(base_reg);
    assign scan_inc = idx_inc(scan_ptr_reg);
    assign len_sat  = (len_reg > LEN_W'(PAYLOAD_MAX)) ? LEN_W'(PAYLOAD_MAX) : len_reg;
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        sts          = '0;
        sts.kind     = kind_reg;
        sts.crc_ok   = crc_reg;
        sts.beyond   = ({1'b0, seq_ext} >= win_end);
        sts.below    = (seq_ext < ws_reg);
        sts.at_start = (seq_ext == ws_reg);
        sts.out_free = out_free;
        sts.scan_go  = (cnt_reg < wsz_eff) && full_reg[scan_ptr_reg];
        sts.cnt_last = (cnt_reg == CNT_W'(1));
    end

    // input capture
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            kind_reg   <= s_tuser[KIND_W-1:0];
            crc_reg    <= s_tuser[KIND_W];
            seq_reg    <= s_tdata[SEQ_W-1:0];
            handle_reg <= s_tdata[SEQ_W +: HANDLE_W];
            len_reg    <= s_tdata[SEQ_W+HANDLE_W +: LEN_W];
        end
    end

    // window control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wsz_reg      <= WSZ_RESET;
            ws_reg       <= '0;
            open_reg     <= 1'b0;
            full_reg     <= '0;
            base_reg     <= '0;
            scan_ptr_reg <= '0;
            cnt_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                wsz_reg <= cfg_wr_data;
            end
            if (cmd.set_open) begin
                open_reg <= 1'b1;
            end
            if (cmd.fin && open_reg) begin
                open_reg <= 1'b0;
                ws_reg   <= '0;
                full_reg <= '0;
            end
            if (cmd.store) begin
                full_reg[phys] <= 1'b1;
                scan_ptr_reg   <= base_reg;
                cnt_reg        <= '0;
            end
            if (cmd.scan_step) begin
                scan_ptr_reg <= scan_inc;
                cnt_reg      <= cnt_reg + CNT_W'(1);
            end
            if (cmd.advance) begin
                ws_reg <= ws_reg + WS_W'(cnt_reg);
            end
            if (cmd.dlv_load) begin
                full_reg[base_reg] <= 1'b0;
                base_reg           <= base_inc;
                cnt_reg            <= cnt_reg - CNT_W'(1);
            end
        end
    end

    srrw_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (WINDOW_MAX)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (cmd.store),
        .wr_addr (phys),
        .wr_data ({len_sat, handle_reg}),
        .rd_en   (cmd.rd_req),
        .rd_addr (cmd.dlv_load ? base_inc : base_reg),
        .rd_data (rd_data)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.ack_load || cmd.dlv_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ack_load) begin
            out_kind_reg   <= RES_ACK;
            out_last_reg   <= cmd.ack_last;
            out_ack_reg    <= cmd.ack_sel_ws ? ws_reg[SEQ_W-1:0] : seq_reg;
            out_handle_reg <= '0;
            out_len_reg    <= '0;
        end else if (cmd.dlv_load) begin
            out_kind_reg   <= RES_DLV;
            out_last_reg   <= (cnt_reg == CNT_W'(1));
            out_ack_reg    <= '0;
            out_handle_reg <= rd_data[HANDLE_W-1:0];
            out_len_reg    <= rd_data[HANDLE_W +: LEN_W];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_len_reg, out_handle_reg, out_ack_reg};

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// ---------------------------------------------------------------------------
// tb: selective-repeat receive window
// Drives packet beats into the window, predicts the acknowledgement and
// in-order delivery beats with an independent model of the window state or
// the directed table, and checks every result beat against them. A short table
// of directed packets comes first. Random phases follow, each starting with a
// window size write. Both stream sides stall at random except in one calm phase.
// ---------------------------------------------------------------------------
module tb
    import srrw_pkg::*;
();

    localparam logic [KIND_W-1:0] KIND_OTHER = 2'd3;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASES        = 9;
    localparam int PHASE_ITEMS   = 28;

    typedef enum logic [1:0] {ROW_PRED, ROW_QUIET, ROW_ACK} row_mode_t;

    typedef struct packed {
        row_mode_t        mode;
        logic [SEQ_W-1:0] ack;
    } row_note_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [SEQ_W-1:0]    seq;
        logic                crc_ok;
        logic [HANDLE_W-1:0] handle;
        logic [LEN_W-1:0]    len;
        row_mode_t           mode;
        logic [SEQ_W-1:0]    ack;
    } pkt_row_t;

    typedef struct packed {
        logic                kind;
        logic [SEQ_W-1:0]    ack;
        logic [HANDLE_W-1:0] handle;
        logic [LEN_W-1:0]    len;
        logic                last;
    } beat_t;

    localparam pkt_row_t DIRECTED [18] = '{
        '{KIND_OTHER, 31'd5,          1'b1, 16'h0001, 11'd1,    ROW_QUIET, 31'd0},
        '{KIND_DATA,  31'd0,          1'b0, 16'h0002, 11'd2,    ROW_QUIET, 31'd0},
        '{KIND_DATA,  31'd16,         1'b1, 16'h0003, 11'd3,    ROW_QUIET, 31'd0},
        '{KIND_DATA,  31'h7fffffff,   1'b1, 16'h0004, 11'd4,    ROW_QUIET, 31'd0},
        '{KIND_SYN,   31'h7fffffff,   1'b1, 16'hffff, 11'd2047, ROW_ACK,   31'h7fffffff},
        '{KIND_SYN,   31'd0,          1'b0, 16'h0000, 11'd0,    ROW_ACK,   31'd0},
        '{KIND_DATA,  31'd2,          1'b1, 16'hffff, 11'd2047, ROW_ACK,   31'd0},
        '{KIND_DATA,  31'd2,          1'b1, 16'h1234, 11'd1024, ROW_ACK,   31'd0},
        '{KIND_DATA,  31'd15,         1'b1, 16'h0000, 11'd0,    ROW_ACK,   31'd0},
        '{KIND_DATA,  31'd1,          1'b1, 16'haaaa, 11'd1025, ROW_ACK,   31'd0},
        '{KIND_DATA,  31'd0,          1'b1, 16'h5555, 11'd1,    ROW_PRED,  31'd0},
        '{KIND_DATA,  31'd0,          1'b1, 16'h00ff, 11'd7,    ROW_ACK,   31'd3},
        '{KIND_DATA,  31'd2,          1'b1, 16'hff00, 11'd9,    ROW_ACK,   31'd3},
        '{KIND_FIN,   31'h2aaaaaaa,   1'b1, 16'h0000, 11'd0,    ROW_ACK,   31'h2aaaaaaa},
        '{KIND_FIN,   31'h55555555,   1'b0, 16'h0000, 11'd0,    ROW_ACK,   31'h55555555},
        '{KIND_DATA,  31'd3,          1'b1, 16'h0f0f, 11'd512,  ROW_ACK,   31'd0},
        '{KIND_DATA,  31'd0,          1'b1, 16'h0000, 11'd0,    ROW_PRED,  31'd0},
        '{KIND_DATA,  31'd17,         1'b1, 16'hbeef, 11'd33,   ROW_QUIET, 31'd0}
    };

    localparam logic [WSZ_W-1:0] SIZES [PHASES-1] = '{
        5'd1, 5'd0, 5'd31, 5'd16, 5'd3, 5'd17, 5'd8, 5'd16
    };

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [WSZ_W-1:0]       cfg_wr_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;    // seq_num, payload_handle, payload_len
    logic [IN_TUSER_W-1:0]  s_tuser;    // packet_kind, crc_ok
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;    // ack_seq, deliver_handle, deliver_len
    logic                   m_tlast;    // last
    logic [0:0]             m_tuser;    // result_kind

    selective_repeat_receiver_window dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    // window state as predicted
    logic [WSZ_W-1:0]    win_cfg;
    logic [WS_W-1:0]     win_start;
    logic                xfer_open;
    logic                slot_full [WINDOW_MAX];
    logic [HANDLE_W-1:0] slot_handle [WINDOW_MAX];
    logic [LEN_W-1:0]    slot_len [WINDOW_MAX];

    beat_t     owed_beats [$];
    beat_t     step_beats [$];
    row_note_t row_notes [$];
    int        fails;
    bit        calm;

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    function automatic int live_window();
        if (win_cfg == 0) return 1;
        if (win_cfg > WINDOW_MAX) return WINDOW_MAX;
        return int'(win_cfg);
    endfunction

    function automatic void note_beat(logic kind, logic [SEQ_W-1:0] ack,
                                      logic [HANDLE_W-1:0] handle, logic [LEN_W-1:0] len);
        beat_t b;
        b.kind   = kind;
        b.ack    = ack;
        b.handle = handle;
        b.len    = len;
        b.last   = 1'b0;
        step_beats.push_back(b);
    endfunction

    task automatic window_step(input logic [KIND_W-1:0] kind, input logic [SEQ_W-1:0] seq,
                               input logic crc_ok, input logic [HANDLE_W-1:0] handle,
                               input logic [LEN_W-1:0] len);
        int              wsz;
        int              idx;
        int              cnt;
        int              k;
        logic [LEN_W-1:0] held_len;
        logic [WS_W-1:0]  ws;
        wsz = live_window();
        ws = win_start;
        held_len = (len > PAYLOAD_MAX) ? LEN_W'(PAYLOAD_MAX) : len;
        step_beats.delete();
        case (kind)
            KIND_SYN: begin
                note_beat(RES_ACK, seq, '0, '0);
                xfer_open = 1'b1;
            end
            KIND_FIN: begin
                note_beat(RES_ACK, seq, '0, '0);
                if (xfer_open) begin
                    xfer_open = 1'b0;
                    win_start = '0;
                    for (k = 0; k < WINDOW_MAX; k++) slot_full[k] = 1'b0;
                end
            end
            KIND_DATA: begin
                if (longint'(seq) < longint'(ws) + wsz && crc_ok) begin
                    if (longint'(seq) < longint'(ws)) begin
                        note_beat(RES_ACK, ws[SEQ_W-1:0], '0, '0);
                    end else begin
                        idx = int'(WS_W'(seq) - ws);
                        slot_full[idx] = 1'b1;
                        slot_handle[idx] = handle;
                        slot_len[idx] = held_len;
                        if (idx != 0) begin
                            note_beat(RES_ACK, ws[SEQ_W-1:0], '0, '0);
                        end else begin
                            cnt = 0;
                            while (cnt < wsz && slot_full[cnt]) cnt++;
                            win_start = ws + WS_W'(cnt);
                            note_beat(RES_ACK, win_start[SEQ_W-1:0], '0, '0);
                            for (k = 0; k < cnt; k++)
                                note_beat(RES_DLV, '0, slot_handle[k], slot_len[k]);
                            for (k = 0; k + cnt < WINDOW_MAX; k++) begin
                                slot_full[k] = slot_full[k + cnt];
                                slot_handle[k] = slot_handle[k + cnt];
                                slot_len[k] = slot_len[k + cnt];
                            end
                            for (; k < WINDOW_MAX; k++) slot_full[k] = 1'b0;
                        end
                    end
                end
            end
            default: ;
        endcase
        if (step_beats.size() > 0) step_beats[step_beats.size() - 1].last = 1'b1;
    endtask

    // predict on each accepted packet beat, check each accepted result beat
    always @(posedge aclk) begin
        row_note_t note;
        beat_t     got;
        beat_t     want;
        if (aresetn) begin
            if (cfg_wr_en) win_cfg = cfg_wr_data;
            if (s_tvalid && s_tready) begin
                note = row_notes.pop_front();
                window_step(s_tuser[KIND_W-1:0], s_tdata[SEQ_W-1:0], s_tuser[KIND_W],
                            s_tdata[SEQ_W +: HANDLE_W], s_tdata[SEQ_W+HANDLE_W +: LEN_W]);
                case (note.mode)
                    ROW_PRED: foreach (step_beats[i]) owed_beats.push_back(step_beats[i]);
                    ROW_ACK:  owed_beats.push_back('{RES_ACK, note.ack, '0, '0, 1'b1});
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.kind   = m_tuser[0];
                got.ack    = m_tdata[SEQ_W-1:0];
                got.handle = m_tdata[SEQ_W +: HANDLE_W];
                got.len    = m_tdata[SEQ_W+HANDLE_W +: LEN_W];
                got.last   = m_tlast;
                if (owed_beats.size() == 0) begin
                    fails++;
                    $display("%0t expected no beat, got %0d/%0d/%h/%0d/%0d",
                             $time, got.kind, got.ack, got.handle, got.len, got.last);
                end else begin
                    want = owed_beats.pop_front();
                    if (got.kind !== want.kind || got.ack !== want.ack ||
                        got.handle !== want.handle || got.len !== want.len ||
                        got.last !== want.last) begin
                        fails++;
                        $display("%0t expected %0d/%0d/%h/%0d/%0d got %0d/%0d/%h/%0d/%0d",
                                 $time, want.kind, want.ack, want.handle, want.len,
                                 want.last, got.kind, got.ack, got.handle, got.len,
                                 got.last);
                    end
                end
            end
        end
    end

    always @(negedge aclk) m_tready <= calm || ($urandom_range(99) >= 34);

    task automatic send_packet(input pkt_row_t r);
        while (!calm && $urandom_range(99) < 34) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W-SEQ_W-HANDLE_W-LEN_W){1'b0}}, r.len, r.handle, r.seq};
        s_tuser  <= {r.crc_ok, r.kind};
        row_notes.push_back('{r.mode, r.ack});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        while (owed_beats.size() != 0 || row_notes.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [LEN_W-1:0] random_len();
        if ($urandom_range(3) == 0) return LEN_W'($urandom_range(2047, PAYLOAD_MAX + 1));
        return LEN_W'($urandom_range(PAYLOAD_MAX));
    endfunction

    task automatic random_burst(output int sent);
        int              pick;
        int              wsz;
        int              c;
        int              j;
        int              t;
        int              tmp;
        int              order [WINDOW_MAX];
        logic [WS_W-1:0] base;
        pkt_row_t        r;
        sent = 0;
        pick = $urandom_range(99);
        wsz = live_window();
        base = win_start;
        r.kind = KIND_DATA;
        r.crc_ok = 1'b1;
        r.mode = ROW_PRED;
        r.ack = '0;
        if (pick < 60) begin
            // fill part or all of the window in shuffled or descending order
            c = $urandom_range(wsz, 1);
            for (j = 0; j < c; j++) order[j] = j;
            for (j = c - 1; j > 0; j--) begin
                t = $urandom_range(j);
                tmp = order[j];
                order[j] = order[t];
                order[t] = tmp;
            end
            if ($urandom_range(2) == 0) begin
                for (j = 0; j < c; j++) order[j] = c - 1 - j;
            end
            for (j = 0; j < c; j++) begin
                r.seq = SEQ_W'(base + WS_W'(order[j]));
                r.crc_ok = ($urandom_range(99) >= 8);
                r.handle = HANDLE_W'($urandom);
                r.len = random_len();
                send_packet(r);
                sent++;
                if ($urandom_range(9) == 0) begin
                    send_packet(r);
                    sent++;
                end
            end
        end else begin
            r.seq = SEQ_W'($urandom);
            r.crc_ok = 1'($urandom_range(1));
            r.handle = HANDLE_W'($urandom);
            r.len = random_len();
            if (pick < 68) begin
                r.kind = KIND_SYN;
            end else if (pick < 73) begin
                r.kind = KIND_FIN;
            end else if (pick < 80) begin
                r.kind = KIND_OTHER;
            end else if (pick < 90) begin
                r.crc_ok = 1'b1;
                if (base > 0) r.seq = SEQ_W'($urandom_range(base - 1, 0));
                else r.seq = SEQ_W'(base + WS_W'(wsz) + WS_W'($urandom_range(3)));
            end
            send_packet(r);
            if (r.kind != KIND_OTHER) sent++;
        end
    endtask

    initial begin
        int phase;
        int phase_items;
        int got;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        calm        = 1'b0;
        fails       = 0;
        win_cfg     = WSZ_RESET;
        win_start   = '0;
        xfer_open   = 1'b0;
        for (int k = 0; k < WINDOW_MAX; k++) begin
            slot_full[k]   = 1'b0;
            slot_handle[k] = '0;
            slot_len[k]    = '0;
        end
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int k = 0; k < $size(DIRECTED); k++) send_packet(DIRECTED[k]);
        s_tvalid <= 1'b0;

        for (phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= (phase < PHASES - 1) ? SIZES[phase] : WSZ_W'($urandom_range(31));
            @(negedge aclk);
            cfg_wr_en <= 1'b0;
            calm = (phase == 3);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                random_burst(got);
                phase_items += got;
            end
            s_tvalid <= 1'b0;
        end

        calm = 1'b0;
        wait_idle();
        if (fails == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #4000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
